// ===== rtl/core/dpf_pkg.sv =====
// Shared types, sizes and helpers for the deduplicating packet FIFO.
// No dependencies; imported by the top level and by the port checker.
package dpf_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int ID_BITS     = 16;
  localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] ID_MASK = (ID_BITS >= 16) ? 16'hFFFF : 16'((1 << ID_BITS) - 1);
  localparam logic [6:0]  COUNT_MAX   = 7'd127;
  localparam logic [6:0]  LIMIT_RESET = 7'd64;

  // Operation codes carried in s_tuser
  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_FWD   = 2'd1,
    KIND_COUNT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // One stored packet
  typedef struct packed {
    logic [31:0] timestamp;
    logic [15:0] destination;
    logic [15:0] source;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Input request payload, last field (source) in the lowest bits
  typedef struct packed {
    logic [31:0] end_time;
    logic [31:0] start_time;
    logic [31:0] timestamp;
    logic [15:0] destination;
    logic [15:0] source;
  } req_t;

  // Result payload, last field (accepted) in the lowest bits, padded to 80 bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [6:0]  match_count;
    logic [31:0] out_timestamp;
    logic [15:0] out_destination;
    logic [15:0] out_source;
    logic        has_packet;
    logic        accepted;
  } result_t;

  // Circular slot of base + off, off never above QUEUE_DEPTH
  function automatic logic [ADDR_W-1:0] slot_add(logic [ADDR_W-1:0] base,
                                                 logic [OCC_W-1:0]  off);
    logic [OCC_W:0] sum;
    sum = (OCC_W+1)'(base) + (OCC_W+1)'(off);
    if (sum >= (OCC_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (OCC_W+1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/dpf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module dpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/dedup_packet_fifo_with_range_count_top.sv =====
// Deduplicating bounded packet FIFO with destination/time range count.
// Depends on dpf_pkg and dpf_ram.
//
// Every request on the slave stream gets exactly one result on the master
// stream. s_tuser carries the operation: add a (source, destination,
// timestamp) packet, forward the oldest packet, or count queued packets for
// a destination whose timestamp lies in [start_time, end_time]. Packets live
// in one RAM with a single read port and a registered read, so an add or a
// count reads every queued entry, one per cycle; a stored add then writes the
// RAM. A forward reads the oldest slot; a forward on an empty queue or an
// unused operation goes straight to the result. One request is in flight at a
// time; s_tready is high only while the block waits for a request, and a
// finished result sits in the output register so the next request can be
// taken while it waits. An add that matches a queued packet is refused
// (accepted = 0); a stored add that leaves the queue above memory_limit drops
// the oldest packet silently. The user must write memory_limit through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce
// it. 0 acts as 1 and values above the depth act as the depth. The RAM needs
// no clearing after reset: only slots inside the queued window are ever read.
module dedup_packet_fifo_with_range_count_top (
  input  logic         clk,
  input  logic         rst,
  // request: source, destination, timestamp, start_time, end_time
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,
  // request: kind
  input  logic [1:0]   s_tuser,
  // result: accepted, has_packet, out_source, out_destination,
  //         out_timestamp, match_count, zero padding
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,
  // memory_limit register
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata
);

  import dpf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FWD_RD,
    ST_FWD_DATA,
    ST_ADD_WR,
    ST_DONE
  } state_t;

  state_t             state;
  logic [ADDR_W-1:0]  head;
  logic [OCC_W-1:0]   occ;
  logic [6:0]         limit;

  kind_t              req_kind;
  req_t               req;
  result_t            res;

  logic [OCC_W-1:0]   issue_cnt;
  logic               rd_pend;
  logic               dup;
  logic [6:0]         cnt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_q;
  entry_t             q;

  req_t               s_req;
  entry_t             req_entry;
  logic               scan_issue;
  logic               hit_dup;
  logic               hit_cnt;
  logic [OCC_W-1:0]   lim_eff;
  logic               drop;
  logic               out_free;

  // Effective limit: zero acts as one, anything above the depth as the depth
  always_comb begin
    if (limit == 7'd0) begin
      lim_eff = OCC_W'(1);
    end else if (32'(limit) > 32'(QUEUE_DEPTH)) begin
      lim_eff = OCC_W'(QUEUE_DEPTH);
    end else begin
      lim_eff = OCC_W'(limit);
    end
  end

  assign s_req    = req_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Identifiers are kept modulo 2^ID_BITS
  assign req_entry.source      = req.source & ID_MASK;
  assign req_entry.destination = req.destination & ID_MASK;
  assign req_entry.timestamp   = req.timestamp;

  // Scan: issue one read per cycle until every queued slot has been read
  assign scan_issue = (state == ST_SCAN) && (issue_cnt != occ);
  assign q          = entry_t'(ram_q);
  assign hit_dup    = rd_pend && (q == req_entry);
  assign hit_cnt    = rd_pend && (q.destination == req_entry.destination) &&
                      (q.timestamp >= req.start_time) && (q.timestamp <= req.end_time);

  // A stored add drops the oldest when the queue would exceed the limit;
  // either way the new packet lands at head + occupancy
  assign drop      = (occ >= lim_eff);
  assign ram_we    = (state == ST_ADD_WR);
  assign ram_waddr = slot_add(head, occ);
  assign ram_wdata = req_entry;
  assign ram_re    = scan_issue || (state == ST_FWD_RD);
  assign ram_raddr = (state == ST_FWD_RD) ? head : slot_add(head, issue_cnt);

  dpf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      occ      <= '0;
      limit    <= LIMIT_RESET;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end

      // Raise a finished result; drop it once the consumer has taken it
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            req_kind  <= kind_t'(s_tuser);
            req       <= s_req;
            res       <= '0;
            issue_cnt <= '0;
            rd_pend   <= 1'b0;
            dup       <= 1'b0;
            cnt       <= '0;
            case (kind_t'(s_tuser))
              KIND_ADD, KIND_COUNT: state <= ST_SCAN;
              KIND_FWD:             state <= (occ != '0) ? ST_FWD_RD : ST_DONE;
              default:              state <= ST_DONE;
            endcase
          end
        end

        ST_SCAN: begin
          if (scan_issue) begin
            issue_cnt <= issue_cnt + OCC_W'(1);
          end
          rd_pend <= scan_issue;
          if (hit_dup) begin
            dup <= 1'b1;
          end
          if (hit_cnt && (cnt != COUNT_MAX)) begin
            cnt <= cnt + 7'd1;
          end
          // Finish once the last read has been compared
          if (!scan_issue && !rd_pend) begin
            if (req_kind == KIND_ADD) begin
              state <= dup ? ST_DONE : ST_ADD_WR;
            end else begin
              res.match_count <= cnt;
              state           <= ST_DONE;
            end
          end
        end

        ST_FWD_RD: begin
          state <= ST_FWD_DATA;
        end

        ST_FWD_DATA: begin
          res.has_packet      <= 1'b1;
          res.out_source      <= q.source;
          res.out_destination <= q.destination;
          res.out_timestamp   <= q.timestamp;
          head                <= slot_add(head, OCC_W'(1));
          occ                 <= occ - OCC_W'(1);
          state               <= ST_DONE;
        end

        ST_ADD_WR: begin
          res.accepted <= 1'b1;
          if (drop) begin
            head <= slot_add(head, OCC_W'(1));
          end else begin
            occ <= occ + OCC_W'(1);
          end
          state <= ST_DONE;
        end

        ST_DONE: begin
          // Hold until the output register is free
          if (out_free) begin
            m_tdata <= res;
            state   <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/dpf_chk.sv =====
// Port-level checker for the deduplicating packet FIFO, bound to the top.
// Depends on dpf_pkg and dedup_packet_fifo_with_range_count_top.
module dpf_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  import dpf_pkg::*;

  result_t r;
  assign r = result_t'(m_tdata);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or vanished while stalled");

  // One request in flight: ready falls after an accepted request
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another was in flight");

  // A result reports at most one operation
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones({r.accepted, r.has_packet, (r.match_count != 7'd0)}) <= 1)
    else $error("result mixes fields of different operations");

  // Packet fields only with a forwarded packet, padding zero without one
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !r.has_packet |->
      (r.out_source == '0) && (r.out_destination == '0) && (r.out_timestamp == '0) &&
      (r.pad == '0))
    else $error("packet fields set without a forwarded packet");

  // A count never exceeds the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(r.match_count) <= 32'(QUEUE_DEPTH)))
    else $error("match count above queue depth");

endmodule

bind dedup_packet_fifo_with_range_count_top dpf_chk u_dpf_chk (.*);

// ===== tb/dedup_packet_fifo_with_range_count_top_test.sv =====
// Self-checking bench for the deduplicating bounded packet FIFO with range count.
// Depends on dpf_pkg and dedup_packet_fifo_with_range_count_top; drives both
// streams with random gaps and checks every result against a shadow queue.
module dedup_packet_fifo_with_range_count_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dpf_pkg::*;

  // Generous bound for about 1200 requests in the worst case, plus drains and
  // configuration pauses, taken several times over.
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 7;
  localparam int PHASE_REQS  = 170;

  // Shadow of the queue: holds the packets in arrival order, the limit register
  // and the results still owed by the block.
  class dedup_fifo_shadow;
    entry_t      held[$];
    result_t     expected_results[$];
    logic [6:0]  limit_reg;
    int unsigned errors;

    function new();
      limit_reg = LIMIT_RESET;
      errors    = 0;
    endfunction

    function void set_limit(logic [6:0] value);
      limit_reg = value;
    endfunction

    // Zero acts as one, anything above the depth acts as the depth.
    function int unsigned capacity();
      if (limit_reg == 0) return 1;
      if (limit_reg > QUEUE_DEPTH) return QUEUE_DEPTH;
      return 32'(limit_reg);
    endfunction

    function void note_request(kind_t kind, req_t req);
      result_t     want;
      entry_t      pkt;
      logic        dup;
      int unsigned hits;
      want = '0;
      dup  = 1'b0;
      hits = 0;
      case (kind)
        KIND_ADD: begin
          // the duplicate search covers the packet this add might drop
          foreach (held[i]) begin
            if (held[i].source == req.source && held[i].destination == req.destination &&
                held[i].timestamp == req.timestamp) dup = 1'b1;
          end
          if (!dup) begin
            if (held.size() + 1 > capacity()) void'(held.pop_front());
            pkt.source      = req.source & ID_MASK;
            pkt.destination = req.destination & ID_MASK;
            pkt.timestamp   = req.timestamp;
            held = {held, pkt};
            want.accepted = 1'b1;
          end
        end
        KIND_FWD: begin
          if (held.size() != 0) begin
            pkt = held.pop_front();
            want.has_packet      = 1'b1;
            want.out_source      = pkt.source;
            want.out_destination = pkt.destination;
            want.out_timestamp   = pkt.timestamp;
          end
        end
        KIND_COUNT: begin
          foreach (held[i]) begin
            if (held[i].destination == (req.destination & ID_MASK) &&
                held[i].timestamp >= req.start_time && held[i].timestamp <= req.end_time &&
                hits < COUNT_MAX) hits++;
          end
          want.match_count = hits[6:0];
        end
        default: ;
      endcase
      expected_results = {expected_results, want};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
      compare_field("has_packet", 32'(want.has_packet), 32'(got.has_packet));
      compare_field("out_source", 32'(want.out_source), 32'(got.out_source));
      compare_field("out_destination", 32'(want.out_destination),
                    32'(got.out_destination));
      compare_field("out_timestamp", want.out_timestamp, got.out_timestamp);
      compare_field("match_count", 32'(want.match_count), 32'(got.match_count));
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;   // source, destination, timestamp, start_time, end_time
  logic [1:0]   s_tuser;   // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;   // accepted, has_packet, out_source, out_destination,
                           // out_timestamp, match_count, zero padding
  logic         cfg_we;
  logic [6:0]   cfg_wdata;

  dedup_fifo_shadow shadow = new();

  int unsigned cycle_count = 0;
  logic [31:0] time_cursor = 32'd100;  // drifting timestamp so counts find packets
  bit          tx_quiet = 1'b0;        // sender in a stretch with no gaps
  bit          rx_quiet = 1'b0;        // receiver in a stretch with no stalls

  dedup_packet_fifo_with_range_count_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watch both handshakes at the rising edge. Check the result first, then note
  // the request, so the expectation queue stays in order whatever happens.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) shadow.check_result(result_t'(m_tdata));
      if (s_tvalid && s_tready) shadow.note_request(kind_t'(s_tuser), req_t'(s_tdata));
    end
  end

  // Watchdog: abandon the run if the block stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding", $time,
               shadow.expected_results.size());
      $display("[dedup_packet_fifo_with_range_count_top] ERROR");
      $finish;
    end
  end

  // Result side: random stalls before each result, with quiet stretches.
  // Hold tready high across back-to-back results rather than dropping it.
  initial begin : result_sink
    int unsigned stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready && !rst));
      @(negedge clk);
    end
  end

  function automatic req_t pack_req(logic [15:0] src, logic [15:0] dst, logic [31:0] ts,
                                    logic [31:0] t0, logic [31:0] t1);
    req_t r;
    r.source      = src;
    r.destination = dst;
    r.timestamp   = ts;
    r.start_time  = t0;
    r.end_time    = t1;
    return r;
  endfunction

  function automatic req_t draw_noise();
    return pack_req(16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
  endfunction

  // Mostly a small pool of identifiers and a drifting clock so that adds
  // collide and counts match; now and then repeat a queued triple, now and
  // then fully random values to toggle every bit.
  function automatic req_t draw_add();
    req_t        r;
    entry_t      pkt;
    int unsigned pick;
    r    = draw_noise();
    pick = $urandom_range(0, 99);
    if (pick < 15 && shadow.held.size() != 0) begin
      pkt           = shadow.held[$urandom_range(0, shadow.held.size() - 1)];
      r.source      = pkt.source;
      r.destination = pkt.destination;
      r.timestamp   = pkt.timestamp;
    end else if (pick >= 30) begin
      time_cursor   = time_cursor + $urandom_range(0, 2);
      r.source      = 16'($urandom_range(0, 3));
      r.destination = 16'($urandom_range(0, 3));
      r.timestamp   = time_cursor;
    end
    return r;
  endfunction

  function automatic req_t draw_count();
    req_t        r;
    int unsigned pick;
    int unsigned back;
    r    = draw_noise();
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // a window just behind the drifting clock
      back          = $urandom_range(0, 40);
      r.destination = 16'($urandom_range(0, 3));
      r.start_time  = (time_cursor > back) ? time_cursor - back : 32'd0;
      r.end_time    = r.start_time + $urandom_range(0, 40);
    end else if (pick < 80) begin
      r.destination = 16'($urandom_range(0, 3));
      r.start_time  = 32'd0;
      r.end_time    = 32'hFFFF_FFFF;
    end else if (pick < 90) begin
      // reversed window never matches
      r.destination = 16'($urandom_range(0, 3));
      r.end_time    = time_cursor - $urandom_range(1, 20);
      r.start_time  = r.end_time + $urandom_range(1, 20);
    end
    return r;
  endfunction

  // Present one request after a random gap and hold it until taken. Leave
  // tvalid high when the next gap is zero.
  task automatic drive_request(kind_t kind, req_t req);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) tx_quiet = ~tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tuser  <= kind;
    s_tdata  <= req;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  // Drop tvalid and hold until every owed result has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic [6:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow.set_limit(value);
  endtask

  task automatic random_request(int unsigned add_pct);
    int unsigned pick;
    int unsigned rest;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = 100 - add_pct;
    rest = pick - add_pct;
    if (pick < add_pct) drive_request(KIND_ADD, draw_add());
    else if (rest < span * 4 / 10) drive_request(KIND_FWD, draw_noise());
    else if (rest < span * 9 / 10) drive_request(KIND_COUNT, draw_count());
    else drive_request(KIND_NONE, draw_noise());
  endtask

  initial begin : stimulus
    logic [6:0] phase_limit [PHASES];
    req_t       pkt_a;
    req_t       pkt_b;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = KIND_ADD;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part under the reset limit: empty queue, field extremes,
    // duplicate refusal, reversed and full ranges, unused kind.
    drive_request(KIND_FWD, pack_req('0, '0, '0, '0, '0));
    drive_request(KIND_COUNT, pack_req('0, '0, '0, '0, '1));
    drive_request(KIND_NONE, pack_req('1, '1, '1, '1, '1));
    drive_request(KIND_ADD, pack_req('0, '0, '0, '0, '0));
    drive_request(KIND_ADD, pack_req('1, '1, '1, '1, '1));
    drive_request(KIND_ADD, pack_req('1, '1, '1, '0, '0));
    drive_request(KIND_ADD, pack_req('1, '0, '0, '1, '1));
    drive_request(KIND_COUNT, pack_req('1, '0, '1, '0, '0));
    drive_request(KIND_COUNT, pack_req('0, '1, '0, '1, '1));
    drive_request(KIND_COUNT, pack_req('0, '0, '0, 32'd5, 32'd0));
    drive_request(KIND_COUNT, pack_req('0, '0, '0, '0, '1));
    drive_request(KIND_COUNT, pack_req('0, '1, '0, '1, 32'hFFFF_FFFE));
    drive_request(KIND_FWD, pack_req('1, '1, '1, '1, '1));
    drive_request(KIND_FWD, pack_req('0, '0, '0, '0, '0));
    drive_request(KIND_FWD, pack_req('0, '0, '0, '0, '0));
    drive_request(KIND_FWD, pack_req('0, '0, '0, '0, '0));
    wait_for_results();

    // Limit settings per phase: zero, one, above the depth, a random middle
    // value, the full depth, then a drop below the fill level, and back.
    phase_limit = '{7'd0, 7'd1, 7'd127, 7'd0, 7'd64, 7'd3, 7'd64};
    phase_limit[3] = 7'($urandom_range(2, 63));

    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limit[p]);
      if (phase_limit[p] == 7'd1) begin
        // one slot: a repeat of the only packet is still refused, a new one
        // pushes the old one out
        pkt_a = pack_req(16'h1234, 16'h0002, time_cursor, '0, '0);
        pkt_b = pack_req(16'h4321, 16'h0002, time_cursor, '0, '0);
        drive_request(KIND_ADD, pkt_a);
        drive_request(KIND_ADD, pkt_a);
        drive_request(KIND_ADD, pkt_b);
        drive_request(KIND_FWD, pkt_a);
        drive_request(KIND_FWD, pkt_a);
      end
      for (int n = 0; n < PHASE_REQS; n++) begin
        // fill hard at the full depth so the later lowering finds a full queue
        random_request(phase_limit[p] == 7'd64 ? 80 : 50);
        if ($urandom_range(0, 99) == 0) wait_for_results();
      end
      wait_for_results();
    end

    // Let the last result settle, then report.
    repeat (80) @(posedge clk);
    if (shadow.errors == 0 && shadow.expected_results.size() == 0) begin
      $display("[dedup_packet_fifo_with_range_count_top] OK");
    end else begin
      $display("[dedup_packet_fifo_with_range_count_top] ERROR");
    end
    $finish;
  end

endmodule
